[src/scle_pkg.sv]
// shared types, constants and the keymap table of the scancode line editor
package scle_pkg;

    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 25;

    localparam int SCANCODE_W = 8;
    localparam int CAP_W      = 9;
    localparam int ATTR_W     = 8;
    localparam int LPOS_W     = 8;
    localparam int CELL_W     = 11;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_CAPACITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTRIBUTE = 2'd1;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 9'd128;
    localparam logic [CAP_W-1:0]  CAP_MAX    = 9'd256;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h1F;

    localparam logic [SCANCODE_W-1:0] CODE_ENTER     = 8'h1C;
    localparam logic [SCANCODE_W-1:0] CODE_BACKSPACE = 8'h0E;
    localparam int                    RELEASE_BIT    = 7;
    localparam logic [CHAR_W-1:0]     CHAR_SPACE     = 8'h20;

    localparam int QUEUE_DEPTH = 2;

    localparam int KEYMAP_LEN = 59;
    localparam int KEYMAP_IW  = $clog2(KEYMAP_LEN);

    localparam logic [CHAR_W-1:0] KEYMAP [KEYMAP_LEN] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ENTER,
        OP_BACKSPACE,
        OP_CHAR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic              buffer_write;
        logic [LPOS_W-1:0] buffer_index;
        logic [CHAR_W-1:0] buffer_byte;
        logic              cell_write;
        logic [CELL_W-1:0] cell_index;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic              line_done;
        logic              off_screen;
    } result_t;

endpackage

[src/scle_scan_if.sv]
// scancode input channel
interface scle_scan_if
    import scle_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [SCANCODE_W-1:0] scancode;

    modport source (output valid, output scancode, input ready);
    modport sink   (input valid, input scancode, output ready);
endinterface

[src/scle_result_if.sv]
// result output channel
interface scle_result_if
    import scle_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              buffer_write;
    logic [LPOS_W-1:0] buffer_index;
    logic [CHAR_W-1:0] buffer_byte;
    logic              cell_write;
    logic [CELL_W-1:0] cell_index;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic              line_done;
    logic              off_screen;

    modport source (output valid, input ready, output buffer_write, output buffer_index,
                    output buffer_byte, output cell_write, output cell_index,
                    output cell_char, output cell_attr, output line_done, output off_screen);
    modport sink   (input valid, output ready, input buffer_write, input buffer_index,
                    input buffer_byte, input cell_write, input cell_index,
                    input cell_char, input cell_attr, input line_done, input off_screen);
endinterface

[src/scle_front.sv]
// front end: accepts scancodes and classifies them into commands
module scle_front
    import scle_pkg::*;
(
    scle_scan_if.sink  scan_in,
    input  logic       queue_full,
    output logic       push,
    output cmd_t       cmd
);

    logic [SCANCODE_W-1:0] sc;
    logic [CHAR_W-1:0]     mapped;

    assign sc            = scan_in.scancode;
    assign scan_in.ready = !queue_full;
    assign push          = scan_in.valid && !queue_full;

    always_comb
    begin
        if (int'(sc) < KEYMAP_LEN)
        begin
            mapped = KEYMAP[sc[KEYMAP_IW-1:0]];
        end
        else
        begin
            mapped = '0;
        end
    end

    always_comb
    begin
        cmd.ch = mapped;
        priority if (sc[RELEASE_BIT])
        begin
            cmd.op = OP_NONE;
        end
        else if (sc == CODE_ENTER)
        begin
            cmd.op = OP_ENTER;
        end
        else if (sc == CODE_BACKSPACE)
        begin
            cmd.op = OP_BACKSPACE;
        end
        else if (mapped != '0)
        begin
            cmd.op = OP_CHAR;
        end
        else
        begin
            cmd.op = OP_NONE;
        end
    end

endmodule

[src/scle_queue.sv]
// short command queue between front and back end
module scle_queue
    import scle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_data,
    input  logic pop,
    output cmd_t rd_data,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // entries start as no-op commands so the head is never unknown
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            entry_reg  <= '{default: '0};
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (push)
            begin
                entry_reg[wr_ptr_reg] <= wr_data;
            end
        end
    end

endmodule

[src/scle_back.sv]
// back end: carries out commands on line position and cursor, registers results
module scle_back
    import scle_pkg::*;
#(
    parameter int SCREEN_COLS = SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              pop,
    input  logic [CAP_W-1:0]  line_capacity,
    input  logic [ATTR_W-1:0] text_attribute,
    scle_result_if.source     result_out
);

    localparam int TOTAL = SCREEN_COLS * SCREEN_ROWS;
    localparam int CUR_W = $clog2(TOTAL + 1);
    localparam int ROW_W = $clog2(SCREEN_ROWS + 1);
    localparam int COL_W = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;

    logic [LPOS_W-1:0] lpos_reg, lpos_next;
    logic [CUR_W-1:0]  cur_reg, cur_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              valid_reg, valid_next;
    result_t           res_reg, res_next;

    logic [CAP_W-1:0]  cap_sat;
    logic [CAP_W-1:0]  lpos_inc;
    logic [ROW_W:0]    row_inc;
    logic [CUR_W-1:0]  cur_dec;

    assign pop      = cmd_valid && (!valid_reg || result_out.ready);
    assign cap_sat  = (line_capacity > CAP_MAX) ? CAP_MAX : line_capacity;
    assign lpos_inc = {1'b0, lpos_reg} + 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;
    assign cur_dec  = cur_reg - 1'b1;

    always_comb
    begin
        res_next  = '0;
        lpos_next = lpos_reg;
        cur_next  = cur_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        unique case (cmd.op)
            OP_ENTER:
            begin
                res_next.buffer_write = 1'b1;
                res_next.buffer_index = lpos_reg;
                res_next.line_done    = 1'b1;
                lpos_next             = '0;
                col_next              = '0;
                if (row_inc >= (ROW_W + 1)'(SCREEN_ROWS))
                begin
                    // saturate one past the last cell
                    row_next = ROW_W'(SCREEN_ROWS);
                    cur_next = CUR_W'(TOTAL);
                end
                else
                begin
                    row_next = row_inc[ROW_W-1:0];
                    cur_next = cur_reg - CUR_W'(col_reg) + CUR_W'(SCREEN_COLS);
                end
            end
            OP_BACKSPACE:
            begin
                if (lpos_reg != '0)
                begin
                    lpos_next = lpos_reg - 1'b1;
                    if (cur_reg != '0)
                    begin
                        cur_next            = cur_dec;
                        res_next.cell_write = 1'b1;
                        res_next.cell_index = CELL_W'(cur_dec);
                        res_next.cell_char  = CHAR_SPACE;
                        res_next.cell_attr  = text_attribute;
                        if (col_reg == '0)
                        begin
                            row_next = row_reg - 1'b1;
                            col_next = COL_W'(SCREEN_COLS - 1);
                        end
                        else
                        begin
                            col_next = col_reg - 1'b1;
                        end
                    end
                end
            end
            OP_CHAR:
            begin
                if (lpos_inc < cap_sat)
                begin
                    res_next.buffer_write = 1'b1;
                    res_next.buffer_index = lpos_reg;
                    res_next.buffer_byte  = cmd.ch;
                    lpos_next             = lpos_inc[LPOS_W-1:0];
                    if (row_reg < ROW_W'(SCREEN_ROWS))
                    begin
                        res_next.cell_write = 1'b1;
                        res_next.cell_index = CELL_W'(cur_reg);
                        res_next.cell_char  = cmd.ch;
                        res_next.cell_attr  = text_attribute;
                        cur_next            = cur_reg + 1'b1;
                        if (col_reg == COL_W'(SCREEN_COLS - 1))
                        begin
                            row_next = row_inc[ROW_W-1:0];
                            col_next = '0;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        res_next.off_screen = 1'b1;
                    end
                end
            end
            OP_NONE:
            begin
                res_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpos_reg  <= '0;
            cur_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                lpos_reg <= lpos_next;
                cur_reg  <= cur_next;
                row_reg  <= row_next;
                col_reg  <= col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign result_out.valid        = valid_reg;
    assign result_out.buffer_write = res_reg.buffer_write;
    assign result_out.buffer_index = res_reg.buffer_index;
    assign result_out.buffer_byte  = res_reg.buffer_byte;
    assign result_out.cell_write   = res_reg.cell_write;
    assign result_out.cell_index   = res_reg.cell_index;
    assign result_out.cell_char    = res_reg.cell_char;
    assign result_out.cell_attr    = res_reg.cell_attr;
    assign result_out.line_done    = res_reg.line_done;
    assign result_out.off_screen   = res_reg.off_screen;

endmodule

[src/scancode_line_editor_core.sv]
// top level of the scancode line editor with screen echo
//
// Takes one set 1 keyboard scancode per beat and returns exactly one result
// beat for it, describing the line buffer write, the screen cell write and
// the line end flags it caused. Key releases, unmapped codes, backspace on an
// empty line and typing into a full line return an all-zero result. The block
// sustains one scancode per clock while results are taken; each command is
// registered in the queue and its result then in the output register. The
// rate is set by the back end, which updates the line position and the
// cursor (kept as linear cell, row and column) for each command. The front end
// classifies the scancode through the keymap table and pushes a command into
// a two-entry queue, so input keeps being accepted while a finished result
// waits in the output register; when the output stalls for long the queue
// fills and input ready falls. Configuration (line capacity, text attribute)
// is written through the plain write port; the user must do so only while the
// block is idle, which the block itself does not enforce.
module scancode_line_editor_core
    import scle_pkg::*;
#(
    parameter int SCREEN_COLS = SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    scle_scan_if.sink            scan_in,
    scle_result_if.source        result_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAP_W-1:0]     cfg_data
);

    // configuration registers
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;

    // front to queue
    logic push;
    cmd_t push_cmd;

    // queue to back
    logic queue_full;
    logic queue_empty;
    logic pop;
    cmd_t head_cmd;

    // register writes, unknown indexes are dropped
    always_comb
    begin
        cap_next  = cap_reg;
        attr_next = attr_reg;
        if (cfg_we)
        begin
            priority if (cfg_index == REG_LINE_CAPACITY)
            begin
                cap_next = cfg_data;
            end
            else if (cfg_index == REG_TEXT_ATTRIBUTE)
            begin
                attr_next = cfg_data[ATTR_W-1:0];
            end
            else
            begin
                cap_next = cap_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_RESET;
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            cap_reg  <= cap_next;
            attr_reg <= attr_next;
        end
    end

    // classify incoming scancodes
    scle_front u_front (
        .scan_in    (scan_in),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    // decouple front from back
    scle_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_cmd),
        .pop     (pop),
        .rd_data (head_cmd),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    // execute commands against line and cursor state
    scle_back #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (!queue_empty),
        .cmd            (head_cmd),
        .pop            (pop),
        .line_capacity  (cap_reg),
        .text_attribute (attr_reg),
        .result_out     (result_out)
    );

endmodule

[src/scle_checker.sv]
// port level checks of the line editor and their binding to the top level
module scle_checker
    import scle_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic              buffer_write,
    input logic [LPOS_W-1:0] buffer_index,
    input logic [CHAR_W-1:0] buffer_byte,
    input logic              cell_write,
    input logic [CELL_W-1:0] cell_index,
    input logic [CHAR_W-1:0] cell_char,
    input logic [ATTR_W-1:0] cell_attr,
    input logic              line_done,
    input logic              off_screen
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(buffer_write)
            && $stable(buffer_index) && $stable(buffer_byte) && $stable(cell_write)
            && $stable(cell_index) && $stable(cell_char) && $stable(cell_attr)
            && $stable(line_done) && $stable(off_screen))
        else $error("result beat changed while stalled");

    // enter writes the terminating zero and never a cell
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && line_done |-> buffer_write && buffer_byte == '0 && !cell_write
            && !off_screen)
        else $error("line end without terminating zero");

    // suppressed echo still stores the character
    a_off: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && off_screen |-> buffer_write && buffer_byte != '0 && !cell_write
            && !line_done)
        else $error("off screen flag with wrong fields");

    // a cell write without a buffer write is an erase
    a_erase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && cell_write && !buffer_write |-> cell_char == CHAR_SPACE)
        else $error("erase did not write a space");

endmodule

bind scancode_line_editor_core scle_checker u_scle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result_out.valid),
    .res_ready    (result_out.ready),
    .buffer_write (result_out.buffer_write),
    .buffer_index (result_out.buffer_index),
    .buffer_byte  (result_out.buffer_byte),
    .cell_write   (result_out.cell_write),
    .cell_index   (result_out.cell_index),
    .cell_char    (result_out.cell_char),
    .cell_attr    (result_out.cell_attr),
    .line_done    (result_out.line_done),
    .off_screen   (result_out.off_screen)
);
